/* rtl/core/mnep_pkg.sv */
// shared types and constants for the midi note event parser
package mnep_pkg;

    typedef enum logic [1:0]
    {
        CMD_MIDI  = 2'd0,
        CMD_START = 2'd1,
        CMD_QUERY = 2'd2
    } command_t;

    typedef enum logic [2:0]
    {
        PH_IDLE   = 3'd0,
        PH_NOTE   = 3'd1,
        PH_VEL    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_FFLEN  = 3'd4,
        PH_FFSKIP = 3'd5
    } phase_t;

    localparam logic RESULT_EVENT = 1'b0;
    localparam logic RESULT_QUERY = 1'b1;

    localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
    localparam logic [3:0] KIND_POLY_AT   = 4'hA;
    localparam logic [3:0] KIND_CONTROL   = 4'hB;
    localparam logic [3:0] KIND_PROGRAM   = 4'hC;
    localparam logic [3:0] KIND_CHAN_AT   = 4'hD;
    localparam logic [3:0] KIND_PITCH     = 4'hE;
    localparam logic [7:0] DATA_MAX       = 8'h7F;
    localparam logic [7:0] STATUS_META    = 8'hFF;

    localparam int NOTE_COUNT = 128;

    typedef struct packed
    {
        logic [7:0] status_byte;
        phase_t     phase;
        logic [7:0] bytes_to_skip;
        logic [7:0] pending_note;
    } parse_state_t;

    typedef struct packed
    {
        logic       valid;
        logic       note_on;
        logic [7:0] note_number;
        logic [7:0] velocity;
    } note_event_t;

endpackage

/* rtl/core/midi_note_event_parser_unit.sv */
// midi note event parser: running status parse, note-active map and result register
//
// input stream s_*: one item per midi byte, start command or note query;
// s_tuser carries the command, s_tdata the byte and its millisecond timestamp.
// output stream m_*: note events (m_tuser low) and query answers (m_tuser high).
// each item is parsed in the cycle it is accepted; a result, if any, appears on
// m_* in the next cycle from the result register.
// throughput is one item per cycle: s_tready stays high while the result
// register is empty or being taken, so a stalled receiver holds one result and
// stops the input only while that result waits.
// the parse state and the 128-bit note-active map are flip-flops; a query reads
// the map as updated by every earlier item, including the one just before.
// reset clears the parse state, the map and the result register at once; a
// start command does the same for the parse state and the map, with no result.
module midi_note_event_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], timestamp[39:8]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // note_on[0], event_time[32:1], note_number[40:33],
                                   // velocity[48:41], zero[55:49]
    output logic        m_tuser    // result_kind[0]
);
    import mnep_pkg::*;

    command_t     command;
    logic [7:0]   data_byte;
    logic [31:0]  timestamp;
    logic         s_accept;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t parser_next;
    note_event_t  note_event;

    logic [NOTE_COUNT-1:0] note_map_reg;
    logic [NOTE_COUNT-1:0] note_map_next;
    logic                  query_active;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_kind_reg;
    logic         out_kind_next;
    logic         out_note_on_reg;
    logic         out_note_on_next;
    logic [31:0]  out_time_reg;
    logic [31:0]  out_time_next;
    logic [7:0]   out_note_reg;
    logic [7:0]   out_note_next;
    logic [7:0]   out_vel_reg;
    logic [7:0]   out_vel_next;
    logic         result_valid;

    assign command   = command_t'(s_tuser);
    assign data_byte = s_tdata[7:0];
    assign timestamp = s_tdata[39:8];
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    mnep_parser u_parser
    (
        .state      (state_reg),
        .data_byte  (data_byte),
        .state_next (parser_next),
        .note_event (note_event)
    );

    assign query_active = !data_byte[7] && note_map_reg[data_byte[6:0]];

    always_comb
    begin
        state_next       = state_reg;
        note_map_next    = note_map_reg;
        result_valid     = 1'b0;
        out_kind_next    = out_kind_reg;
        out_note_on_next = out_note_on_reg;
        out_time_next    = out_time_reg;
        out_note_next    = out_note_reg;
        out_vel_next     = out_vel_reg;
        if (s_accept)
        begin
            case (command)
                CMD_START:
                begin
                    state_next    = '{status_byte: 8'd0, phase: PH_IDLE,
                                      bytes_to_skip: 8'd0, pending_note: 8'd0};
                    note_map_next = '0;
                end
                CMD_QUERY:
                begin
                    result_valid     = 1'b1;
                    out_kind_next    = RESULT_QUERY;
                    out_note_on_next = query_active;
                    out_time_next    = 32'd0;
                    out_note_next    = data_byte;
                    out_vel_next     = 8'd0;
                end
                CMD_MIDI:
                begin
                    state_next = parser_next;
                    if (note_event.valid)
                    begin
                        result_valid     = 1'b1;
                        out_kind_next    = RESULT_EVENT;
                        out_note_on_next = note_event.note_on;
                        out_time_next    = timestamp;
                        out_note_next    = note_event.note_number;
                        out_vel_next     = note_event.velocity;
                        if (!note_event.note_number[7])
                        begin
                            note_map_next[note_event.note_number[6:0]] = note_event.note_on;
                        end
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        if (result_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{status_byte: 8'd0, phase: PH_IDLE,
                               bytes_to_skip: 8'd0, pending_note: 8'd0};
            note_map_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            note_map_reg  <= note_map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg    <= out_kind_next;
        out_note_on_reg <= out_note_on_next;
        out_time_reg    <= out_time_next;
        out_note_reg    <= out_note_next;
        out_vel_reg     <= out_vel_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_vel_reg, out_note_reg, out_time_reg, out_note_on_reg};

    // start leaves an empty map and an idle parser
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && command == CMD_START |=> note_map_reg == '0 &&
        state_reg.phase == PH_IDLE && state_reg.status_byte == 8'd0)
        else $error("start did not clear map and parser");

    // meta status is never kept as running status
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.status_byte != STATUS_META)
        else $error("meta status held as running status");

    // query answers carry no time and no velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == RESULT_QUERY |-> out_time_reg == 32'd0 &&
        out_vel_reg == 8'd0)
        else $error("query answer with time or velocity");

    // a midi byte in the velocity phase always yields an event
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && command == CMD_MIDI && state_reg.phase == PH_VEL |=>
        m_tvalid && m_tuser == RESULT_EVENT)
        else $error("velocity byte gave no event");

endmodule

/* rtl/core/mnep_parser.sv */
// next parse state and note event for one received midi byte
module mnep_parser
(
    input  mnep_pkg::parse_state_t state,
    input  logic [7:0]             data_byte,
    output mnep_pkg::parse_state_t state_next,
    output mnep_pkg::note_event_t  note_event
);
    import mnep_pkg::*;

    function automatic parse_state_t start_message(parse_state_t s, logic [7:0] b);
        parse_state_t r;
        logic         is_status;
        logic [3:0]   kind;
        logic [1:0]   n;
        r         = s;
        is_status = b > DATA_MAX;
        if (is_status)
        begin
            r.status_byte = b;
        end
        kind    = r.status_byte[7:4];
        r.phase = PH_IDLE;
        if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF)
        begin
            if (is_status)
            begin
                r.phase = PH_NOTE;
            end
            else
            begin
                r.pending_note = b;
                r.phase        = PH_VEL;
            end
        end
        else if (kind == KIND_POLY_AT || kind == KIND_CONTROL || kind == KIND_PITCH ||
                 kind == KIND_PROGRAM || kind == KIND_CHAN_AT)
        begin
            n = (kind == KIND_PROGRAM || kind == KIND_CHAN_AT) ? 2'd1 : 2'd2;
            if (!is_status)
            begin
                n = n - 2'd1;
            end
            r.bytes_to_skip = {6'd0, n};
            if (n != 2'd0)
            begin
                r.phase = PH_SKIP;
            end
        end
        else if (r.status_byte == STATUS_META)
        begin
            r.status_byte = 8'd0;
            r.phase       = PH_FFLEN;
        end
        return r;
    endfunction

    logic [7:0] skip_dec;

    assign skip_dec = state.bytes_to_skip - 8'd1;

    always_comb
    begin
        state_next             = state;
        note_event.valid       = 1'b0;
        note_event.note_on     = 1'b0;
        note_event.note_number = state.pending_note;
        note_event.velocity    = data_byte;
        case (state.phase)
            PH_NOTE:
            begin
                state_next.pending_note = data_byte;
                state_next.phase        = PH_VEL;
            end
            PH_VEL:
            begin
                note_event.valid   = 1'b1;
                note_event.note_on = (state.status_byte[7:4] == KIND_NOTE_ON) &&
                                     (data_byte != 8'd0);
                state_next.phase   = PH_IDLE;
            end
            PH_SKIP:
            begin
                if (data_byte > DATA_MAX)
                begin
                    state_next = start_message(state, data_byte);
                end
                else
                begin
                    state_next.bytes_to_skip = skip_dec;
                    if (skip_dec == 8'd0)
                    begin
                        state_next.phase = PH_IDLE;
                    end
                end
            end
            PH_FFLEN:
            begin
                state_next.bytes_to_skip = data_byte;
                state_next.phase         = (data_byte == 8'd0) ? PH_IDLE : PH_FFSKIP;
            end
            PH_FFSKIP:
            begin
                state_next.bytes_to_skip = skip_dec;
                if (skip_dec == 8'd0)
                begin
                    state_next.phase = PH_IDLE;
                end
            end
            default:
            begin
                state_next = start_message(state, data_byte);
            end
        endcase
    end

endmodule
